[sv/ddq_pkg.sv]
// Deque package: field widths, operation and status codes, cell controls, FSM states.
// No dependencies; used by ddq_cell and double_ended_queue_top.
package ddq_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

    // Controls broadcast to every cell of the row; at most one is set per cycle.
    typedef struct packed {
        logic shift_right;  // push at front: everything moves one cell toward rear
        logic shift_left;   // pop at front: everything moves one cell toward front
        logic push_rear;    // first empty cell takes the new word
        logic pop_rear;     // last occupied cell drops its word
        logic rotate;       // list step: front word wraps around to the rear
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REAR,
        S_LIST
    } ctrl_state_t;

endpackage

[sv/ddq_cell.sv]
// One storage cell of the deque row: a word and its occupied flag.
// Depends on ddq_pkg (WORD_W, cell_op_t).
module ddq_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddq_pkg::cell_op_t          op,
    input  logic [ddq_pkg::WORD_W-1:0] left_data,
    input  logic                       left_valid,
    input  logic [ddq_pkg::WORD_W-1:0] right_data,
    input  logic                       right_valid,
    input  logic [ddq_pkg::WORD_W-1:0] push_value,
    input  logic [ddq_pkg::WORD_W-1:0] wrap_data,
    output logic [ddq_pkg::WORD_W-1:0] data,
    output logic                       valid,
    output logic                       is_last
);

    logic [ddq_pkg::WORD_W-1:0] data_reg;
    logic [ddq_pkg::WORD_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       last_here;

    assign last_here = valid_reg && !right_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (op.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (op.push_rear)
        begin
            // first free cell behind an occupied one
            if (!valid_reg && left_valid)
            begin
                data_next  = push_value;
                valid_next = 1'b1;
            end
        end
        else if (op.pop_rear)
        begin
            if (last_here)
            begin
                valid_next = 1'b0;
            end
        end
        else if (op.rotate)
        begin
            if (last_here)
            begin
                data_next = wrap_data;
            end
            else if (valid_reg)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign valid   = valid_reg;
    assign is_last = last_here;

endmodule

[sv/double_ended_queue_top.sv]
// Bounded deque of signed 32-bit words held in a row of DEPTH shifting cells.
// Push front/rear and pop front: result registered next cycle after acceptance.
// Pop rear: sent from S_REAR (registered OR tree picks the last occupied cell).
// List: one result per word, one per cycle unless stalled; row rotates once fully.
// Throughput: one item at a time; a new item waits for idle and a free result slot.
// Reset (rst_n, async, active low) empties the row; stored words need no clearing.
module double_ended_queue_top
#(
    parameter int DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ddq_pkg::KIND_W-1:0]          kind,
    input  logic signed [ddq_pkg::WORD_W-1:0]   push_value,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ddq_pkg::STATUS_W-1:0]        status,
    output logic signed [ddq_pkg::WORD_W-1:0]   out_value,
    output logic [ddq_pkg::OCC_W-1:0]           occupancy,
    output logic                                last
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int GROUP  = 8;
    localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

    // ------------------------------------------------------------------
    // Cell row. Cell 0 holds the front word; occupied cells are packed
    // from cell 0 upward, so the rear is the last occupied cell.
    // ------------------------------------------------------------------
    ddq_pkg::cell_op_t          cell_op;
    logic [ddq_pkg::WORD_W-1:0] cell_data  [DEPTH];
    logic                       cell_valid [DEPTH];
    logic                       cell_last  [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ddq_pkg::WORD_W-1:0] l_data;
            logic                       l_valid;
            logic [ddq_pkg::WORD_W-1:0] r_data;
            logic                       r_valid;

            if (gi == 0)
            begin : g_front
                // front neighbor is the incoming word, always present
                assign l_data  = push_value;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data  = cell_data[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_rear
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data  = cell_data[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            ddq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .push_value  (push_value),
                .wrap_data   (cell_data[0]),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi]),
                .is_last     (cell_last[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Rear word pick: one-hot OR over the row, first level registered.
    // ------------------------------------------------------------------
    logic [NGROUP-1:0][ddq_pkg::WORD_W-1:0] group_or;
    logic [NGROUP-1:0][ddq_pkg::WORD_W-1:0] group_reg;
    logic [ddq_pkg::WORD_W-1:0]             rear_word;

    always_comb
    begin
        group_or = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < DEPTH)
                begin
                    if (cell_last[g * GROUP + j])
                    begin
                        group_or[g] = group_or[g] | cell_data[g * GROUP + j];
                    end
                end
            end
        end
    end

    always_comb
    begin
        rear_word = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            rear_word = rear_word | group_reg[g];
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    ddq_pkg::ctrl_state_t state_reg;
    ddq_pkg::ctrl_state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] list_reg;     // list results still to send
    logic [CNT_W-1:0] list_next;

    logic out_valid_reg;
    logic [ddq_pkg::STATUS_W-1:0] status_reg;
    logic [ddq_pkg::STATUS_W-1:0] status_next;
    logic [ddq_pkg::WORD_W-1:0]   value_reg;
    logic [ddq_pkg::WORD_W-1:0]   value_next;
    logic [ddq_pkg::OCC_W-1:0]    occ_reg;
    logic                         last_reg;
    logic                         last_next;

    logic slot_free;
    logic accept;
    logic q_empty;
    logic q_full;
    logic out_load;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ddq_pkg::S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CNT_W'(DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddq_pkg::S_IDLE:
            begin
                if (accept && !q_empty)
                begin
                    if (kind == ddq_pkg::KIND_POP_REAR)
                    begin
                        state_next = ddq_pkg::S_REAR;
                    end
                    else if (kind == ddq_pkg::KIND_LIST)
                    begin
                        state_next = ddq_pkg::S_LIST;
                    end
                end
            end
            ddq_pkg::S_REAR:
            begin
                if (slot_free)
                begin
                    state_next = ddq_pkg::S_IDLE;
                end
            end
            ddq_pkg::S_LIST:
            begin
                if (slot_free && list_reg == CNT_W'(1))
                begin
                    state_next = ddq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ddq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: cell controls, result payload, count updates
    always_comb
    begin
        cell_op     = '0;
        out_load    = 1'b0;
        status_next = ddq_pkg::ST_PUSHED;
        value_next  = '0;
        last_next   = 1'b1;
        count_next  = count_reg;
        list_next   = list_reg;
        unique case (state_reg)
            ddq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind) inside
                        ddq_pkg::KIND_PUSH_FRONT, ddq_pkg::KIND_PUSH_REAR:
                        begin
                            out_load = 1'b1;
                            if (q_full)
                            begin
                                status_next = ddq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cell_op.shift_right = (kind == ddq_pkg::KIND_PUSH_FRONT);
                                cell_op.push_rear   = (kind == ddq_pkg::KIND_PUSH_REAR);
                                count_next          = count_reg + CNT_W'(1);
                                status_next         = ddq_pkg::ST_PUSHED;
                            end
                        end
                        ddq_pkg::KIND_POP_FRONT, ddq_pkg::KIND_POP_REAR:
                        begin
                            if (q_empty)
                            begin
                                out_load    = 1'b1;
                                status_next = ddq_pkg::ST_UNDERFLOW;
                            end
                            else if (kind == ddq_pkg::KIND_POP_FRONT)
                            begin
                                out_load         = 1'b1;
                                cell_op.shift_left = 1'b1;
                                count_next       = count_reg - CNT_W'(1);
                                status_next      = ddq_pkg::ST_POPPED;
                                value_next       = cell_data[0];
                            end
                            else
                            begin
                                // word leaves the row now; S_REAR sends the result
                                cell_op.pop_rear = 1'b1;
                                count_next       = count_reg - CNT_W'(1);
                            end
                        end
                        ddq_pkg::KIND_LIST:
                        begin
                            if (q_empty)
                            begin
                                out_load    = 1'b1;
                                status_next = ddq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                list_next = count_reg;
                            end
                        end
                        default:
                        begin
                            // unused codes: taken, no result
                        end
                    endcase
                end
            end
            ddq_pkg::S_REAR:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    status_next = ddq_pkg::ST_POPPED;
                    value_next  = rear_word;
                end
            end
            ddq_pkg::S_LIST:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    cell_op.rotate = 1'b1;
                    status_next    = ddq_pkg::ST_LISTED;
                    value_next     = cell_data[0];
                    last_next      = (list_reg == CNT_W'(1));
                    list_next      = list_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddq_pkg::S_IDLE;
            count_reg     <= '0;
            list_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            list_reg  <= list_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ddq_pkg::S_IDLE)
        begin
            group_reg <= group_or;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            occ_reg    <= ddq_pkg::OCC_W'(count_next);
            last_reg   <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

[test/double_ended_queue_top_tb.sv]
// Self-checking testbench for double_ended_queue_top: directed and random deque traffic.
// Depends on ddq_pkg (codes and widths) and the double_ended_queue_top RTL; nothing else.
module double_ended_queue_top_tb;

    localparam int DEPTH          = 64;
    // Generous watchdog limit for the slowest legal run.
    localparam int TIMEOUT_CYCLES = 400000;
    // Quiet cycles after the last expected transfer; catches stray transfers.
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 10;
    localparam int REPORT_LIMIT   = 10;

    // One pending request; a hold entry makes the sender wait for an empty scoreboard.
    typedef struct {
        bit                                 hold;
        logic [ddq_pkg::KIND_W-1:0]         kind;
        logic signed [ddq_pkg::WORD_W-1:0]  value;
    } deque_req_t;

    // One expected response transfer.
    typedef struct {
        logic [ddq_pkg::STATUS_W-1:0]       status;
        logic signed [ddq_pkg::WORD_W-1:0]  value;
        logic [ddq_pkg::OCC_W-1:0]          occupancy;
        logic                               last;
    } deque_rsp_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_ready;
    logic [ddq_pkg::KIND_W-1:0]          kind       = ddq_pkg::KIND_PUSH_FRONT;
    logic signed [ddq_pkg::WORD_W-1:0]   push_value = '0;
    logic                                out_valid;
    logic                                out_ready  = 1'b0;
    logic [ddq_pkg::STATUS_W-1:0]        status;
    logic signed [ddq_pkg::WORD_W-1:0]   out_value;
    logic [ddq_pkg::OCC_W-1:0]           occupancy;
    logic                                last;

    // Stimulus and scoreboard
    deque_req_t                  req_q[$];
    deque_rsp_t                  rsp_q[$];
    deque_req_t                  next_req;
    deque_rsp_t                  got_rsp;
    deque_rsp_t                  want_rsp;
    int                          rsp_expected = 0;  // transfers predicted (sender side)
    int                          rsp_received = 0;  // transfers seen (receiver side)
    int                          fail_count   = 0;
    int                          cycle_cnt    = 0;
    int                          gen_level    = 0;  // rough occupancy while building stimulus

    // Sender pacing
    int                          burst_left   = 4;
    int                          gap_left     = 0;
    logic                        next_valid;

    // Shadow deque: ring store, front pointer and fill level
    logic signed [ddq_pkg::WORD_W-1:0] ring_mem [DEPTH];
    int                          front_ptr    = 0;
    int                          fill_level   = 0;

    double_ended_queue_top #(
        .DEPTH      (DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_value  (out_value),
        .occupancy  (occupancy),
        .last       (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0d] %s", cycle_cnt, msg);
        end
    endtask

    // Appends one expected transfer; occupancy is the level after the operation.
    task automatic expect_rsp(input logic [ddq_pkg::STATUS_W-1:0] st,
                              input logic signed [ddq_pkg::WORD_W-1:0] val,
                              input logic is_last);
        rsp_q.push_back('{st, val, ddq_pkg::OCC_W'(fill_level), is_last});
        rsp_expected++;
    endtask

    // Applies one accepted request to the shadow deque and queues what it must produce.
    task automatic deque_apply(input logic [ddq_pkg::KIND_W-1:0] op,
                               input logic signed [ddq_pkg::WORD_W-1:0] word);
        int rear_pos;
        case (op) inside
            ddq_pkg::KIND_PUSH_FRONT, ddq_pkg::KIND_PUSH_REAR:
            begin
                if (fill_level >= DEPTH)
                begin
                    // full: word dropped, contents unchanged
                    expect_rsp(ddq_pkg::ST_OVERFLOW, '0, 1'b1);
                end
                else
                begin
                    if (op == ddq_pkg::KIND_PUSH_FRONT)
                    begin
                        front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                        ring_mem[front_ptr] = word;
                    end
                    else
                    begin
                        ring_mem[(front_ptr + fill_level) % DEPTH] = word;
                    end
                    fill_level++;
                    expect_rsp(ddq_pkg::ST_PUSHED, '0, 1'b1);
                end
            end
            ddq_pkg::KIND_POP_FRONT, ddq_pkg::KIND_POP_REAR:
            begin
                if (fill_level == 0)
                begin
                    expect_rsp(ddq_pkg::ST_UNDERFLOW, '0, 1'b1);
                end
                else if (op == ddq_pkg::KIND_POP_FRONT)
                begin
                    rear_pos = front_ptr;
                    front_ptr = (front_ptr + 1) % DEPTH;
                    fill_level--;
                    expect_rsp(ddq_pkg::ST_POPPED, ring_mem[rear_pos], 1'b1);
                end
                else
                begin
                    rear_pos = (front_ptr + fill_level - 1) % DEPTH;
                    fill_level--;
                    expect_rsp(ddq_pkg::ST_POPPED, ring_mem[rear_pos], 1'b1);
                end
            end
            ddq_pkg::KIND_LIST:
            begin
                if (fill_level == 0)
                begin
                    expect_rsp(ddq_pkg::ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    // front to rear, last flag on the rear word only
                    for (int i = 0; i < fill_level; i++)
                    begin
                        expect_rsp(ddq_pkg::ST_LISTED, ring_mem[(front_ptr + i) % DEPTH],
                                   i == fill_level - 1);
                    end
                end
            end
            default:
            begin
                // unused codes: no transfer, no state change
            end
        endcase
    endtask

    // Builds the request list; gen_level follows occupancy only to steer the phases.
    task automatic add_req(input logic [ddq_pkg::KIND_W-1:0] op,
                           input logic signed [ddq_pkg::WORD_W-1:0] word);
        req_q.push_back('{1'b0, op, word});
        if ((op == ddq_pkg::KIND_PUSH_FRONT || op == ddq_pkg::KIND_PUSH_REAR)
            && gen_level < DEPTH)
        begin
            gen_level++;
        end
        else if ((op == ddq_pkg::KIND_POP_FRONT || op == ddq_pkg::KIND_POP_REAR)
                 && gen_level > 0)
        begin
            gen_level--;
        end
    endtask

    task automatic add_hold();
        req_q.push_back('{1'b1, ddq_pkg::KIND_LIST, '0});
    endtask

    function automatic logic [ddq_pkg::KIND_W-1:0] pick_kind(input traffic_mix_t mix);
        int                         roll;
        logic [ddq_pkg::KIND_W-1:0] grow;
        logic [ddq_pkg::KIND_W-1:0] shrink;
        logic [ddq_pkg::KIND_W-1:0] junk;
        roll   = $urandom_range(0, 99);
        grow   = $urandom_range(0, 1) ? ddq_pkg::KIND_PUSH_FRONT : ddq_pkg::KIND_PUSH_REAR;
        shrink = $urandom_range(0, 1) ? ddq_pkg::KIND_POP_FRONT : ddq_pkg::KIND_POP_REAR;
        junk   = ddq_pkg::KIND_LIST + ddq_pkg::KIND_W'($urandom_range(1, 3));
        case (mix)
            MIX_FILL:  return roll < 88 ? grow   : roll < 93 ? shrink :
                              roll < 97 ? ddq_pkg::KIND_LIST : junk;
            MIX_DRAIN: return roll < 88 ? shrink : roll < 93 ? grow   :
                              roll < 97 ? ddq_pkg::KIND_LIST : junk;
            default:   return roll < 40 ? grow   : roll < 80 ? shrink :
                              roll < 93 ? ddq_pkg::KIND_LIST : junk;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: walks req_q in bursts with random gaps. Prediction happens
    // on the transfer edge, so the scoreboard order follows the DUT order.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= ddq_pkg::KIND_PUSH_FRONT;
            push_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                deque_apply(kind, push_value);
            end
            // Payload may change only when nothing is waiting on the channel.
            if (!in_valid || in_ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (req_q.size() != 0)
                begin
                    if (req_q[0].hold)
                    begin
                        // rsp_received is registered, so this compare is race free
                        if (rsp_expected == rsp_received)
                        begin
                            void'(req_q.pop_front());
                        end
                    end
                    else
                    begin
                        next_req   = req_q.pop_front();
                        next_valid = 1'b1;
                        kind       <= next_req.kind;
                        push_value <= next_req.value;
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1, 16);
                            // a quarter of the bursts run straight on
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each transfer against the oldest expectation.
    // out_ready follows a rotating pattern: always ready, coin flip,
    // one in five, and four in seven, in turn.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rsp_received <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_rsp = '{status, out_value, occupancy, last};
                if (rsp_q.size() == 0)
                begin
                    log_failure($sformatf({"unexpected transfer: status %0d value %0d ",
                                           "occ %0d last %0b"},
                                          status, out_value, occupancy, last));
                end
                else
                begin
                    want_rsp = rsp_q.pop_front();
                    if (got_rsp.status !== want_rsp.status || got_rsp.value !== want_rsp.value
                        || got_rsp.occupancy !== want_rsp.occupancy
                        || got_rsp.last !== want_rsp.last)
                    begin
                        log_failure($sformatf({"mismatch: expected status %0d value %0d occ %0d ",
                                               "last %0b, got status %0d value %0d occ %0d last %0b"},
                                              want_rsp.status, want_rsp.value,
                                              want_rsp.occupancy, want_rsp.last,
                                              got_rsp.status, got_rsp.value,
                                              got_rsp.occupancy, got_rsp.last));
                    end
                end
                rsp_received <= rsp_received + 1;
            end
            case ((cycle_cnt / 97) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (cycle_cnt % 5) == 0;
                default: out_ready <= (cycle_cnt % 7) >= 3;
            endcase
        end
    end

    // Watchdog
    initial
    begin
        wait (cycle_cnt >= TIMEOUT_CYCLES);
        $display("double_ended_queue_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: empty-queue cases, word extremes, both ends, wrap of the
        // front pointer below zero, and the unused operation codes.
        add_req(ddq_pkg::KIND_LIST,       '0);
        add_req(ddq_pkg::KIND_POP_FRONT,  32'sh1234_5678);
        add_req(ddq_pkg::KIND_POP_REAR,   '0);
        add_req(ddq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
        add_req(ddq_pkg::KIND_PUSH_REAR,  32'sh7FFF_FFFF);
        add_req(ddq_pkg::KIND_PUSH_FRONT, '0);
        add_req(ddq_pkg::KIND_PUSH_REAR,  -32'sd1);
        add_req(ddq_pkg::KIND_LIST + ddq_pkg::KIND_W'(1), 32'sh0BAD_F00D);
        add_req(ddq_pkg::KIND_LIST,       '0);
        add_req(ddq_pkg::KIND_LIST + ddq_pkg::KIND_W'(2), '0);
        add_req(ddq_pkg::KIND_POP_REAR,   '0);
        add_req(ddq_pkg::KIND_POP_FRONT,  '0);
        add_req(ddq_pkg::KIND_LIST + ddq_pkg::KIND_W'(3), -32'sd1);
        add_req(ddq_pkg::KIND_LIST,       '0);
        add_req(ddq_pkg::KIND_POP_FRONT,  '0);
        add_req(ddq_pkg::KIND_POP_REAR,   '0);
        add_req(ddq_pkg::KIND_LIST,       '0);
        add_req(ddq_pkg::KIND_POP_REAR,   '0);
        add_req(ddq_pkg::KIND_PUSH_REAR,  32'sh5555_5555);
        add_req(ddq_pkg::KIND_PUSH_FRONT, 32'shAAAA_AAAA);
        add_req(ddq_pkg::KIND_POP_FRONT,  '0);
        add_req(ddq_pkg::KIND_POP_FRONT,  '0);
        add_hold();

        // Random: fill to full and try a few more pushes
        while (gen_level < DEPTH)
        begin
            add_req(pick_kind(MIX_FILL), $urandom());
        end
        for (int i = 0; i < 3; i++)
        begin
            add_req($urandom_range(0, 1) ? ddq_pkg::KIND_PUSH_FRONT : ddq_pkg::KIND_PUSH_REAR,
                    $urandom());
        end
        add_req(ddq_pkg::KIND_LIST, $urandom());
        add_hold();

        // Partial drain from full
        for (int i = 0; i < 16; i++)
        begin
            add_req(pick_kind(MIX_DRAIN), $urandom());
        end
        add_req(ddq_pkg::KIND_LIST, $urandom());

        // Balanced tail
        for (int i = 0; i < 10; i++)
        begin
            add_req(pick_kind(MIX_EVEN), $urandom());
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the active edge so sender updates have settled
        while (req_q.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (rsp_expected != rsp_received)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (rsp_q.size() != 0)
        begin
            log_failure($sformatf("%0d expected transfers never arrived", rsp_q.size()));
        end
        if (fail_count == 0)
        begin
            $display("double_ended_queue_top test passed");
        end
        else
        begin
            $display("double_ended_queue_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/ddq_pkg.sv
sv/ddq_cell.sv
sv/double_ended_queue_top.sv
test/double_ended_queue_top_tb.sv
